/* rtl/lptr_pkg.sv */
// Package: types, constants and the arctangent table for the lidar point time/range filter.
`timescale 1ns / 1ps
package lptr_pkg;

  localparam int MAX_RINGS_DEF       = 32;
  localparam int ATAN_ITERATIONS_DEF = 20;
  localparam int ATAN_TAB_LEN        = 28;

  localparam logic [26:0] DEG180_Q16 = 27'd11796480;
  localparam logic [26:0] DEG360_Q16 = 27'd23592960;

  localparam logic [31:0] GIVEN_SAT_US = 32'd65536000;
  localparam logic [26:0] RECIP_125_A  = 27'd68719477;
  localparam logic [20:0] RECIP_125_C  = 21'd1073742;
  localparam logic [26:0] DIV_125      = 27'd125;
  localparam logic [19:0] GIVEN_ROUND  = 20'd62;

  typedef enum logic [1:0] {
    CFG_GIVEN_TIME_MODE = 2'd0,
    CFG_BLIND_DIST_SQ   = 2'd1,
    CFG_MS_PER_DEGREE   = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DIVIDE,
    ST_MUL,
    ST_ADJ,
    ST_SQ,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic               cloud_start;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [5:0]         ring_index;
    logic [31:0]        raw_time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [31:0]        point_time;
  } out_item_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/lidar_point_time_and_range_filter_unit.sv */
// Top level: per-ring offset time from yaw or timestamp, plus near-range point filter.
//
// Channels: input points on in_valid/in_ready/in_data, filtered points on
// out_valid/out_ready/out_data, register writes on cfg_valid/cfg_ready/cfg_index/cfg_data
// (cfg_ready is always high; write only while idle).
// One point is processed at a time. Yaw mode: accept, ATAN_ITERATIONS CORDIC iterations
// (capped at 28), multiply and adjust, squaring of x, y and z on one shared multiplier,
// and decide. Given-time mode: accept, reciprocal scaling by 1/1000, squaring and decide.
// In yaw mode, the first point of a ring ends after CORDIC and a ring at or above
// MAX_RINGS ends at accept, both with no transaction out. Per-ring first yaw and last time
// live in one synchronous memory of MAX_RINGS entries; a seen flag per ring is cleared
// at reset and on cloud start.
// The result sits in an output register; the next point is accepted while it waits.
// A stalled receiver holds the output and the following point waits in its decide state.
// Reset returns the registers to their defaults and clears the seen flags.
`timescale 1ns / 1ps
module lidar_point_time_and_range_filter_unit
  import lptr_pkg::*;
#(
  parameter int MAX_RINGS       = MAX_RINGS_DEF,
  parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int NITER  = (ATAN_ITERATIONS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : ATAN_ITERATIONS;
  localparam int MEM_W  = 26 + 32;

  logic        given_time_mode;
  logic [47:0] blind_dist_sq;
  logic [23:0] ms_per_degree;

  state_t state, state_next;

  in_item_t           item;
  logic [RING_W-1:0]  ring;
  logic [MAX_RINGS-1:0] seen;
  logic [5:0]         cnt;
  logic signed [26:0] cx, cy, cz;
  logic [19:0]        div_a;
  logic [19:0]        div_c;
  logic [48:0]        prod;
  logic [31:0]        t;
  logic [49:0]        acc;

  logic [MEM_W-1:0]   mem [MAX_RINGS];
  logic [MEM_W-1:0]   mem_q;
  logic               mem_we;
  logic [MEM_W-1:0]   mem_wdata;

  logic               accept;
  logic               ring_ok;
  logic               last_iter;
  logic signed [26:0] dx, dy;
  logic [26:0]        atan_ext;
  logic signed [26:0] cz_step;
  logic signed [26:0] first_yaw;
  logic signed [26:0] diff_raw;
  logic [24:0]        diff;
  logic [33:0]        t_round;
  logic [31:0]        t_sat;
  logic [32:0]        rev;
  logic [33:0]        t_rev;
  logic [31:0]        t_adj;
  logic [52:0]        div_prod_a;
  logic [26:0]        div_rem;
  logic [40:0]        div_prod_c;
  logic [31:0]        t_div;
  logic signed [23:0] sq_op;
  logic signed [47:0] sq;
  logic               out_free;
  logic               pass;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign ring_ok   = {1'b0, in_data.ring_index} < 7'(MAX_RINGS);
  assign last_iter = cnt == 6'(NITER - 1);
  assign out_free  = !out_valid || out_ready;
  assign pass      = acc > {2'b00, blind_dist_sq};

  assign dx        = cy >>> cnt[4:0];
  assign dy        = cx >>> cnt[4:0];
  assign atan_ext  = {5'b0, atan_q16(cnt[4:0])};
  assign cz_step   = (cy > 0) ? cz + $signed(atan_ext) :
                     (cy < 0) ? cz - $signed(atan_ext) : cz;
  assign first_yaw = {mem_q[MEM_W-1], mem_q[MEM_W-1:32]};
  assign diff_raw  = first_yaw - cz;
  assign diff      = diff_raw[26] ? 25'(diff_raw + DEG360_Q16) : diff_raw[24:0];
  assign t_round   = 34'(prod[48:16]) + 34'(prod[15]);
  assign t_sat     = (t_round[33:32] != 2'b00) ? '1 : t_round[31:0];
  assign rev       = 33'(ms_per_degree) * 33'd360;
  assign t_rev     = 34'(t_sat) + 34'(rev);
  assign t_adj     = (t_sat < mem_q[31:0]) ?
                     ((t_rev[33:32] != 2'b00) ? '1 : t_rev[31:0]) : t_sat;
  assign div_prod_a = 53'(item.raw_time_us[25:0]) * 53'(RECIP_125_A);
  assign div_rem    = 27'(item.raw_time_us[25:0]) - 27'(div_a) * DIV_125;
  assign div_prod_c = 41'(div_c) * 41'(RECIP_125_C);
  assign t_div      = {div_a[18:0], 13'd0} + 32'(div_prod_c[40:27]);
  assign sq        = sq_op * sq_op;

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    sq_op = item.pos_x;
      2'd1:    sq_op = item.pos_y;
      default: sq_op = item.pos_z;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (given_time_mode) state_next = ST_DIVIDE;
          else if (ring_ok)    state_next = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (last_iter) state_next = seen[ring] ? ST_MUL : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (cnt == 6'd2) state_next = ST_SQ;
      end
      ST_MUL:    state_next = ST_ADJ;
      ST_ADJ:    state_next = ST_SQ;
      ST_SQ: begin
        if (cnt == 6'd2) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!pass || out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = {first_yaw[25:0], t_adj};
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_CORDIC: begin
        if (last_iter && !seen[ring]) begin
          mem_we    = 1'b1;
          mem_wdata = {cz_step[25:0], 32'd0};
        end
      end
      ST_ADJ:    mem_we = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      given_time_mode <= 1'b0;
      blind_dist_sq   <= 48'd105;
      ms_per_degree   <= 24'd18154;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GIVEN_TIME_MODE: given_time_mode <= cfg_data[0];
        CFG_BLIND_DIST_SQ:   blind_dist_sq   <= cfg_data;
        CFG_MS_PER_DEGREE:   ms_per_degree   <= cfg_data[23:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[ring] <= mem_wdata;
    mem_q <= mem[ring];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !out_ready) || (state == ST_DECIDE && pass && out_free);
      if (accept && in_data.cloud_start) seen <= '0;
      if (state == ST_CORDIC && last_iter && !seen[ring]) seen[ring] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item <= in_data;
        ring <= in_data.ring_index[RING_W-1:0];
        cnt  <= '0;
        acc  <= '0;
        if (in_data.pos_x < 0) begin
          cx <= -27'(in_data.pos_x);
          cy <= -27'(in_data.pos_y);
          cz <= (in_data.pos_y >= 0) ? $signed(DEG180_Q16) : -$signed(DEG180_Q16);
        end else begin
          cx <= 27'(in_data.pos_x);
          cy <= 27'(in_data.pos_y);
          cz <= '0;
        end
      end
      ST_CORDIC: begin
        cnt <= last_iter ? 6'd0 : cnt + 6'd1;
        cz  <= cz_step;
        if (cy > 0) begin
          cx <= cx + dx;
          cy <= cy - dy;
        end else if (cy < 0) begin
          cx <= cx - dx;
          cy <= cy + dy;
        end
      end
      ST_DIVIDE: begin
        if (cnt == 6'd0) div_a <= div_prod_a[52:33];
        if (cnt == 6'd1) div_c <= {div_rem[6:0], 13'd0} + GIVEN_ROUND;
        if (cnt == 6'd2) begin
          t   <= (item.raw_time_us >= GIVEN_SAT_US) ? '1 : t_div;
          cnt <= '0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      ST_MUL: prod <= 49'(diff) * 49'(ms_per_degree);
      ST_ADJ: t <= t_adj;
      ST_SQ: begin
        acc <= acc + 50'(unsigned'(sq));
        cnt <= cnt + 6'd1;
      end
      ST_DECIDE: begin
        if (pass && out_free) begin
          out_data.out_x      <= item.pos_x;
          out_data.out_y      <= item.pos_y;
          out_data.out_z      <= item.pos_z;
          out_data.point_time <= t;
        end
      end
      default: ;
    endcase
  end

endmodule
